[hdl/jsu_pkg.sv]
package jsu_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_BODY = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_HEX1 = 3'd3,
		MODE_HEX2 = 3'd4,
		MODE_HEX3 = 3'd5,
		MODE_HEX4 = 3'd6,
		MODE_HALT = 3'd7
	} mode_t;

	typedef struct packed {
		byte_t out_byte;
		logic  byte_valid;
		logic  string_done;
		logic  error_flag;
		logic  last_of_run;
	} word_t;

	localparam int MAX_RUN    = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int RUN_W      = $clog2(MAX_RUN + 1);

	localparam byte_t CH_QUOTE = 8'h22;
	localparam byte_t CH_BSLASH = 8'h5C;
	localparam byte_t CH_SLASH = 8'h2F;
	localparam byte_t CH_B = 8'h62;
	localparam byte_t CH_F = 8'h66;
	localparam byte_t CH_N = 8'h6E;
	localparam byte_t CH_R = 8'h72;
	localparam byte_t CH_T = 8'h74;
	localparam byte_t CH_U = 8'h75;

	localparam byte_t CTL_BS  = 8'h08;
	localparam byte_t CTL_FF  = 8'h0C;
	localparam byte_t CTL_LF  = 8'h0A;
	localparam byte_t CTL_CR  = 8'h0D;
	localparam byte_t CTL_TAB = 8'h09;

	localparam byte_t LEAD2 = 8'hC0;
	localparam byte_t LEAD3 = 8'hE0;
	localparam byte_t CONT  = 8'h80;
	localparam logic [15:0] MAX_ONE = 16'h007F;
	localparam logic [15:0] MAX_TWO = 16'h07FF;

endpackage

[hdl/jsu_in_if.sv]
interface jsu_in_if;
	logic           valid;
	logic           ready;
	jsu_pkg::byte_t in_byte;
	logic           string_start;

	modport source (output valid, output in_byte, output string_start, input ready);
	modport sink (input valid, input in_byte, input string_start, output ready);
endinterface

[hdl/jsu_out_if.sv]
interface jsu_out_if;
	logic           valid;
	logic           ready;
	jsu_pkg::byte_t out_byte;
	logic           byte_valid;
	logic           string_done;
	logic           error_flag;
	logic           last_of_run;

	modport source (output valid, output out_byte, output byte_valid, output string_done,
		output error_flag, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input string_done,
		input error_flag, input last_of_run, output ready);
endinterface

[hdl/json_string_unescape_utf8.sv]
// Channel   Role   Word
// raw       sink   in_byte, string_start
// decoded   source out_byte, byte_valid, string_done, error_flag, last_of_run
//
// A raw word is decoded in the cycle it is accepted and its results, zero to three
// words, are written into a four-entry result queue; the first one can leave next cycle.
// One raw word is taken per cycle while the queue holds at most one word, so a
// one-word result stream runs at full rate; a three-byte UTF-8 run drains at one word
// per cycle. arst_n clears the decoder to idle and empties the queue.
// A stall on decoded only fills the queue; raw ready drops while it holds over one word.
module json_string_unescape_utf8 (
	input logic         clk,
	input logic         arst_n,
	jsu_in_if.sink      raw,
	jsu_out_if.source   decoded
);

	jsu_pkg::word_t                   fifo_q [jsu_pkg::FIFO_DEPTH];
	logic [jsu_pkg::PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [jsu_pkg::CNT_W-1:0]        count_q;
	jsu_pkg::mode_t                   mode_q, mode_cur, mode_nxt;
	logic [15:0]                      acc_q, acc_cur, acc_nxt, code;
	jsu_pkg::word_t                   ent [jsu_pkg::MAX_RUN];
	logic [jsu_pkg::RUN_W-1:0]        n_words, n_push;
	logic                             raw_acc, pop;
	logic                             hex_ok;
	logic [3:0]                       hex_val;
	jsu_pkg::byte_t                   c;

	function automatic jsu_pkg::word_t data_word(jsu_pkg::byte_t b, logic last);
		jsu_pkg::word_t w;
		w = '0;
		w.out_byte = b;
		w.byte_valid = 1'b1;
		w.last_of_run = last;
		return w;
	endfunction

	assign c = raw.in_byte;
	assign raw.ready = (count_q <= jsu_pkg::CNT_W'(jsu_pkg::FIFO_DEPTH - jsu_pkg::MAX_RUN));
	assign raw_acc = raw.valid && raw.ready;
	assign pop = decoded.valid && decoded.ready;

	always_comb begin
		hex_ok = 1'b1;
		hex_val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			hex_val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			hex_val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			hex_val = 4'(c - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		mode_cur = raw.string_start ? jsu_pkg::MODE_BODY : mode_q;
		acc_cur = raw.string_start ? 16'd0 : acc_q;
		code = {acc_cur[11:0], hex_val};
		mode_nxt = mode_cur;
		acc_nxt = acc_cur;
		n_words = '0;
		for (int i = 0; i < jsu_pkg::MAX_RUN; i++) begin
			ent[i] = '0;
		end
		case (mode_cur)
			jsu_pkg::MODE_BODY: begin
				n_words = jsu_pkg::RUN_W'(1);
				if (c == jsu_pkg::CH_BSLASH) begin
					mode_nxt = jsu_pkg::MODE_ESC;
					n_words = '0;
				end else if (c == jsu_pkg::CH_QUOTE) begin
					mode_nxt = jsu_pkg::MODE_HALT;
					ent[0].string_done = 1'b1;
					ent[0].last_of_run = 1'b1;
				end else begin
					ent[0] = data_word(c, 1'b1);
				end
			end
			jsu_pkg::MODE_ESC: begin
				n_words = jsu_pkg::RUN_W'(1);
				mode_nxt = jsu_pkg::MODE_BODY;
				case (c)
					jsu_pkg::CH_QUOTE:  ent[0] = data_word(jsu_pkg::CH_QUOTE, 1'b1);
					jsu_pkg::CH_BSLASH: ent[0] = data_word(jsu_pkg::CH_BSLASH, 1'b1);
					jsu_pkg::CH_SLASH:  ent[0] = data_word(jsu_pkg::CH_SLASH, 1'b1);
					jsu_pkg::CH_B:      ent[0] = data_word(jsu_pkg::CTL_BS, 1'b1);
					jsu_pkg::CH_F:      ent[0] = data_word(jsu_pkg::CTL_FF, 1'b1);
					jsu_pkg::CH_N:      ent[0] = data_word(jsu_pkg::CTL_LF, 1'b1);
					jsu_pkg::CH_R:      ent[0] = data_word(jsu_pkg::CTL_CR, 1'b1);
					jsu_pkg::CH_T:      ent[0] = data_word(jsu_pkg::CTL_TAB, 1'b1);
					jsu_pkg::CH_U: begin
						mode_nxt = jsu_pkg::MODE_HEX1;
						acc_nxt = 16'd0;
						n_words = '0;
					end
					default: begin
						mode_nxt = jsu_pkg::MODE_HALT;
						ent[0].error_flag = 1'b1;
						ent[0].last_of_run = 1'b1;
					end
				endcase
			end
			jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
			jsu_pkg::MODE_HEX4: begin
				if (!hex_ok) begin
					mode_nxt = jsu_pkg::MODE_HALT;
					n_words = jsu_pkg::RUN_W'(1);
					ent[0].error_flag = 1'b1;
					ent[0].last_of_run = 1'b1;
				end else begin
					acc_nxt = code;
					case (mode_cur)
						jsu_pkg::MODE_HEX1: mode_nxt = jsu_pkg::MODE_HEX2;
						jsu_pkg::MODE_HEX2: mode_nxt = jsu_pkg::MODE_HEX3;
						jsu_pkg::MODE_HEX3: mode_nxt = jsu_pkg::MODE_HEX4;
						default: begin
							mode_nxt = jsu_pkg::MODE_BODY;
							if (code <= jsu_pkg::MAX_ONE) begin
								n_words = jsu_pkg::RUN_W'(1);
								ent[0] = data_word(code[7:0], 1'b1);
							end else if (code <= jsu_pkg::MAX_TWO) begin
								n_words = jsu_pkg::RUN_W'(2);
								ent[0] = data_word(jsu_pkg::LEAD2 | {3'b000, code[10:6]}, 1'b0);
								ent[1] = data_word(jsu_pkg::CONT | {2'b00, code[5:0]}, 1'b1);
							end else begin
								n_words = jsu_pkg::RUN_W'(3);
								ent[0] = data_word(jsu_pkg::LEAD3 | {4'b0000, code[15:12]}, 1'b0);
								ent[1] = data_word(jsu_pkg::CONT | {2'b00, code[11:6]}, 1'b0);
								ent[2] = data_word(jsu_pkg::CONT | {2'b00, code[5:0]}, 1'b1);
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	assign n_push = raw_acc ? n_words : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::MODE_IDLE;
			acc_q <= 16'd0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (raw_acc) begin
				mode_q <= mode_nxt;
				acc_q <= acc_nxt;
			end
			wr_ptr_q <= wr_ptr_q + jsu_pkg::PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + jsu_pkg::PTR_W'(1);
			end
			count_q <= count_q + jsu_pkg::CNT_W'(n_push) - jsu_pkg::CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < jsu_pkg::MAX_RUN; i++) begin
			if (jsu_pkg::RUN_W'(i) < n_push) begin
				fifo_q[wr_ptr_q + jsu_pkg::PTR_W'(i)] <= ent[i];
			end
		end
	end

	assign decoded.valid = (count_q != '0);
	assign decoded.out_byte = fifo_q[rd_ptr_q].out_byte;
	assign decoded.byte_valid = fifo_q[rd_ptr_q].byte_valid;
	assign decoded.string_done = fifo_q[rd_ptr_q].string_done;
	assign decoded.error_flag = fifo_q[rd_ptr_q].error_flag;
	assign decoded.last_of_run = fifo_q[rd_ptr_q].last_of_run;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= jsu_pkg::CNT_W'(jsu_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		jsu_pkg::PTR_W'(wr_ptr_q - rd_ptr_q) == jsu_pkg::PTR_W'(count_q))
		else $error("queue pointers disagree with fill count");

	a_halt_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(raw_acc && n_words != '0 && (ent[0].error_flag || ent[0].string_done))
		|=> mode_q == jsu_pkg::MODE_HALT)
		else $error("decoder did not halt after an end or error word");

	a_silent_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(raw_acc && hex_ok && (mode_cur == jsu_pkg::MODE_HEX1
		|| mode_cur == jsu_pkg::MODE_HEX2 || mode_cur == jsu_pkg::MODE_HEX3))
		|=> wr_ptr_q == $past(wr_ptr_q))
		else $error("a leading hex digit produced output");

endmodule
